### design/assert_macros.svh
// Assertion helpers used by the window/level lookup divider stage.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WLCL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wlcl: same-cycle check failed");
`define WLCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wlcl: next-cycle check failed");
`else
`define WLCL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WLCL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/wlcl_pkg.sv
package wlcl_pkg;

   localparam int PIX_W         = 8;
   localparam int CSR_INDEX_W   = 2;
   localparam int STEPS_PER_DIV = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = 2'd3;

   // colour modes; any other code behaves as identity
   localparam logic [1:0] MODE_GRAY       = 2'd0;
   localparam logic [1:0] MODE_RAMP_TABLE = 2'd1;
   localparam logic [1:0] MODE_IDENTITY   = 2'd2;

   // request kinds
   localparam logic REQ_MAP   = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   typedef enum logic [1:0] {
      REGION_RAMP,
      REGION_LOW,
      REGION_HIGH
   } region_type;

   typedef struct packed {
      logic [PIX_W-1:0] black;
      logic [PIX_W-1:0] white;
      logic             reverse;
      logic [1:0]       mode;
   } cfg_type;

   typedef struct packed {
      logic             is_write;
      region_type       region;
      logic [PIX_W-1:0] pixel;
      logic [PIX_W-1:0] rem;
      logic [PIX_W-1:0] dsr;
      logic [PIX_W-1:0] quo;
      logic [PIX_W-1:0] entry_index;
      logic [PIX_W-1:0] entry_red;
      logic [PIX_W-1:0] entry_green;
      logic [PIX_W-1:0] entry_blue;
   } item_type;

endpackage

### design/wlcl_prep.sv
module wlcl_prep (
   input  logic                        clock,
   input  logic                        reset,
   input  wlcl_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_req_type,
   input  logic [wlcl_pkg::PIX_W-1:0]  in_gray_value,
   input  logic [wlcl_pkg::PIX_W-1:0]  in_entry_index,
   input  logic [wlcl_pkg::PIX_W-1:0]  in_entry_red,
   input  logic [wlcl_pkg::PIX_W-1:0]  in_entry_green,
   input  logic [wlcl_pkg::PIX_W-1:0]  in_entry_blue,
   output logic                        out_valid,
   input  logic                        out_ready,
   output wlcl_pkg::item_type          out_item
);

   logic                       valid_ff;
   wlcl_pkg::item_type         item_ff;
   wlcl_pkg::item_type         item_in;
   logic [wlcl_pkg::PIX_W-1:0] black_clamped;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      // limit black to white, then sort the pixel into one of three regions
      black_clamped = (cfg.black > cfg.white) ? cfg.white : cfg.black;
      item_in             = '0;
      item_in.is_write    = (in_req_type == wlcl_pkg::REQ_WRITE);
      item_in.pixel       = in_gray_value;
      item_in.rem         = in_gray_value - black_clamped;
      item_in.dsr         = cfg.white - black_clamped;
      item_in.quo         = '0;
      item_in.entry_index = in_entry_index;
      item_in.entry_red   = in_entry_red;
      item_in.entry_green = in_entry_green;
      item_in.entry_blue  = in_entry_blue;
      if (in_gray_value < black_clamped) begin
         item_in.region = wlcl_pkg::REGION_LOW;
      end else if (in_gray_value >= cfg.white) begin
         item_in.region = wlcl_pkg::REGION_HIGH;
      end else begin
         item_in.region = wlcl_pkg::REGION_RAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

### design/wlcl_div_stage.sv
`include "assert_macros.svh"

module wlcl_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  wlcl_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output wlcl_pkg::item_type out_item
);

   logic                       valid_ff;
   wlcl_pkg::item_type         item_ff;
   wlcl_pkg::item_type         item_in;
   logic [wlcl_pkg::PIX_W:0]   shifted;
   logic [wlcl_pkg::PIX_W-1:0] rem_step;
   logic [wlcl_pkg::PIX_W-1:0] quo_step;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // restoring division, a fixed number of quotient bits per stage
   always_comb begin
      item_in  = in_item;
      rem_step = in_item.rem;
      quo_step = in_item.quo;
      shifted  = '0;
      for (int s = 0; s < wlcl_pkg::STEPS_PER_DIV; s++) begin
         shifted = {rem_step, 1'b0};
         if (shifted >= {1'b0, in_item.dsr}) begin
            shifted  = shifted - {1'b0, in_item.dsr};
            quo_step = {quo_step[wlcl_pkg::PIX_W-2:0], 1'b1};
         end else begin
            quo_step = {quo_step[wlcl_pkg::PIX_W-2:0], 1'b0};
         end
         rem_step = shifted[wlcl_pkg::PIX_W-1:0];
      end
      item_in.rem = rem_step;
      item_in.quo = quo_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   `WLCL_ASSERT_IMPL(rem_below_divisor, clock, reset, valid_ff && !item_ff.is_write && item_ff.region == wlcl_pkg::REGION_RAMP, item_ff.rem < item_ff.dsr)
   `WLCL_ASSERT_NEXT(stalled_item_held, clock, reset, valid_ff && !out_ready, valid_ff && $stable(item_ff))
   `WLCL_ASSERT_NEXT(taken_item_stored, clock, reset, in_valid && in_ready, valid_ff)

endmodule

### design/wlcl_lookup.sv
module wlcl_lookup (
   input  logic                        clock,
   input  logic                        reset,
   input  wlcl_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  wlcl_pkg::item_type          in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [wlcl_pkg::PIX_W-1:0]  out_red,
   output logic [wlcl_pkg::PIX_W-1:0]  out_green,
   output logic [wlcl_pkg::PIX_W-1:0]  out_blue
);

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_GRAY,
      KIND_TABLE
   } kind_type;

   localparam int ENTRY_W = 3 * wlcl_pkg::PIX_W;
   localparam int DEPTH   = 1 << wlcl_pkg::PIX_W;

   logic [ENTRY_W-1:0]         table_mem [DEPTH];
   logic [ENTRY_W-1:0]         rd_data_ff;
   logic                       valid_ff;
   kind_type                   kind_ff;
   kind_type                   kind_in;
   logic [wlcl_pkg::PIX_W-1:0] level_ff;
   logic [wlcl_pkg::PIX_W-1:0] ramp;
   logic [wlcl_pkg::PIX_W-1:0] level_in;
   logic [wlcl_pkg::PIX_W-1:0] rd_index;
   logic                       load;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;

   always_comb begin
      case (in_item.region)
         wlcl_pkg::REGION_LOW:  ramp = '0;
         wlcl_pkg::REGION_HIGH: ramp = wlcl_pkg::PIX_MAX;
         default:               ramp = in_item.quo;
      endcase
      level_in = cfg.reverse ? (wlcl_pkg::PIX_MAX - ramp) : ramp;
      rd_index = (cfg.mode == wlcl_pkg::MODE_RAMP_TABLE) ? level_in : in_item.pixel;
      if (in_item.is_write) begin
         kind_in = KIND_ZERO;
      end else if (cfg.mode == wlcl_pkg::MODE_GRAY) begin
         kind_in = KIND_GRAY;
      end else begin
         kind_in = KIND_TABLE;
      end
   end

   // table write and registered read, both tied to the stage load
   always_ff @(posedge clock) begin
      if (load) begin
         if (in_item.is_write) begin
            table_mem[in_item.entry_index] <=
               {in_item.entry_red, in_item.entry_green, in_item.entry_blue};
         end
         rd_data_ff <= table_mem[rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         level_ff <= level_in;
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_GRAY: begin
            out_red   = level_ff;
            out_green = level_ff;
            out_blue  = level_ff;
         end
         KIND_TABLE: begin
            out_red   = rd_data_ff[ENTRY_W-1 -: wlcl_pkg::PIX_W];
            out_green = rd_data_ff[2*wlcl_pkg::PIX_W-1 -: wlcl_pkg::PIX_W];
            out_blue  = rd_data_ff[wlcl_pkg::PIX_W-1:0];
         end
         default: begin
            out_red   = '0;
            out_green = '0;
            out_blue  = '0;
         end
      endcase
   end

endmodule

### design/window_level_color_lookup.sv
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+-------------------------------
// request  | req_valid / req_ready, req_* fields     | one pixel or one table write
// response | rsp_valid / rsp_ready, rsp_out_* fields | one RGB beat per request beat
// csr      | csr_we, csr_index, csr_wdata            | one register write, no wait
//
// One beat enters per cycle while rsp_ready does not hold the pipeline back; a result
// leaves through the prepare stage, four divider stages of two quotient bits each and
// the colour table stage with its registered read.
// Reset clears every stage valid bit and the registers; the colour table keeps no reset.
// A stalled response holds its stage; earlier stages keep filling any empty slot.
module window_level_color_lookup (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [wlcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wlcl_pkg::PIX_W-1:0]       csr_wdata,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [wlcl_pkg::PIX_W-1:0]       req_gray_value,
   input  logic [wlcl_pkg::PIX_W-1:0]       req_entry_index,
   input  logic [wlcl_pkg::PIX_W-1:0]       req_entry_red,
   input  logic [wlcl_pkg::PIX_W-1:0]       req_entry_green,
   input  logic [wlcl_pkg::PIX_W-1:0]       req_entry_blue,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [wlcl_pkg::PIX_W-1:0]       rsp_out_red,
   output logic [wlcl_pkg::PIX_W-1:0]       rsp_out_green,
   output logic [wlcl_pkg::PIX_W-1:0]       rsp_out_blue
);

   localparam int DIV_STAGES = wlcl_pkg::PIX_W / wlcl_pkg::STEPS_PER_DIV;

   wlcl_pkg::cfg_type  cfg_ff;

   // stage links: index 0 is the prepare stage output, DIV_STAGES the last divider
   logic               link_valid [DIV_STAGES+1];
   logic               link_ready [DIV_STAGES+1];
   wlcl_pkg::item_type link_item  [DIV_STAGES+1];

   // register file: hold values until rewritten
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black   <= '0;
         cfg_ff.white   <= wlcl_pkg::PIX_MAX;
         cfg_ff.reverse <= 1'b0;
         cfg_ff.mode    <= wlcl_pkg::MODE_GRAY;
      end else if (csr_we) begin
         case (csr_index)
            wlcl_pkg::CSR_BLACK:   cfg_ff.black   <= csr_wdata;
            wlcl_pkg::CSR_WHITE:   cfg_ff.white   <= csr_wdata;
            wlcl_pkg::CSR_REVERSE: cfg_ff.reverse <= csr_wdata[0];
            wlcl_pkg::CSR_MODE:    cfg_ff.mode    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // clamp black, classify the pixel and set up numerator and divisor
   wlcl_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_req_type    (req_type),
      .in_gray_value  (req_gray_value),
      .in_entry_index (req_entry_index),
      .in_entry_red   (req_entry_red),
      .in_entry_green (req_entry_green),
      .in_entry_blue  (req_entry_blue),
      .out_valid      (link_valid[0]),
      .out_ready      (link_ready[0]),
      .out_item       (link_item[0])
   );

   // advance the ramp quotient two bits per stage: floor(n * 256 / d) with n < d
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      wlcl_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_item  (link_item[g+1])
      );
   end

   // finish the ramp, apply reverse, then read or write the colour table
   wlcl_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (link_valid[DIV_STAGES]),
      .in_ready  (link_ready[DIV_STAGES]),
      .in_item   (link_item[DIV_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue)
   );

endmodule
